>>> rtl/ihv_pkg.sv
// Shared types, codes and helpers of the IPv4 receive header validator.
`default_nettype none

package ihv_pkg;

    localparam int MID_DEPTH = 2;

    localparam logic [3:0]  IP_VERSION   = 4'd4;
    localparam logic [15:0] MIN_HDR      = 16'd20;
    localparam logic [16:0] MAX_LEN      = 17'd65535;
    localparam logic [15:0] SUM_GOOD     = 16'hffff;
    localparam logic [31:0] SRC_ZERO     = 32'h0000_0000;
    localparam logic [31:0] SRC_BCAST    = 32'hffff_ffff;
    localparam logic [31:0] MCAST_MASK   = 32'hf000_0000;
    localparam logic [31:0] MCAST_PREFIX = 32'he000_0000;

    localparam logic [7:0] PROTO_HOPOPT = 8'd0;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    typedef enum logic [3:0] {
        V_ACCEPT   = 4'd0,
        V_SHORT    = 4'd1,
        V_VERSION  = 4'd2,
        V_HDRLEN   = 4'd3,
        V_TOTLEN   = 4'd4,
        V_PROTO    = 4'd5,
        V_SOURCE   = 4'd6,
        V_FRAGMENT = 4'd7,
        V_CHECKSUM = 4'd8
    } t_verdict;

    typedef enum logic [1:0] {
        L4_NONE = 2'd0,
        L4_TCP  = 2'd1,
        L4_UDP  = 2'd2
    } t_l4_class;

    typedef struct packed {
        logic          early;
        t_verdict      verdict;
        logic [5:0]    hbytes;
        logic [15:0]   pkt;
        logic [15:0]   tot;
        logic [7:0]    proto;
        logic [12:0]   frag;
        logic [31:0]   src;
        logic [1:0]    flags;
        logic [15:0]   sum;
    } t_rec;

    typedef struct packed {
        t_verdict      verdict;
        logic [15:0]   trim_bytes;
        t_l4_class     l4_class;
        logic [5:0]    header_bytes;
        logic [31:0]   source_address;
    } t_result;

    function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [31:0] w);
        logic [17:0] s;
        logic [17:0] s1;
        logic [17:0] s2;
        s  = {2'b00, acc} + {2'b00, w[31:16]} + {2'b00, w[15:0]};
        s1 = {2'b00, s[15:0]} + {16'b0, s[17:16]};
        s2 = {2'b00, s1[15:0]} + {16'b0, s1[17:16]};
        return s2[15:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/ihv_front.sv
// Front end: accepts header words, tracks the packet and classifies early failures.
`default_nettype none

module ihv_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_first_word,
    input  wire logic [31:0]   i_header_word,
    input  wire logic [15:0]   i_segment_length,
    input  wire logic [15:0]   i_packet_length,
    input  wire logic          i_nic_sum_good,
    input  wire logic          i_nic_sum_bad,
    output ihv_pkg::t_rec      o_rec,
    output logic               o_rec_push
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BUSY,
        MODE_SKIP
    } t_mode;

    t_mode         r_mode, n_mode;
    logic [3:0]    r_word_index, n_word_index;
    logic [3:0]    r_header_words, n_header_words;
    logic [15:0]   r_sum, n_sum;
    logic [15:0]   r_pkt, n_pkt;
    logic [15:0]   r_tot, n_tot;
    logic [1:0]    r_flags, n_flags;
    logic [7:0]    r_proto, n_proto;
    logic [12:0]   r_frag, n_frag;
    logic [31:0]   r_src, n_src;

    logic [5:0]        hb_in;
    logic [15:0]       hb_ext;
    logic [15:0]       tot_in;
    logic [3:0]        idx_inc;
    ihv_pkg::t_verdict early_v;

    always_comb begin
        n_mode         = r_mode;
        n_word_index   = r_word_index;
        n_header_words = r_header_words;
        n_sum          = r_sum;
        n_pkt          = r_pkt;
        n_tot          = r_tot;
        n_flags        = r_flags;
        n_proto        = r_proto;
        n_frag         = r_frag;
        n_src          = r_src;
        o_rec          = '0;
        o_rec_push     = 1'b0;

        hb_in   = {i_header_word[27:24], 2'b00};
        hb_ext  = {10'b0, hb_in};
        tot_in  = i_header_word[15:0];
        idx_inc = r_word_index + 4'd1;

        if (i_segment_length < ihv_pkg::MIN_HDR) begin
            early_v = ihv_pkg::V_SHORT;
        end else if (i_header_word[31:28] != ihv_pkg::IP_VERSION) begin
            early_v = ihv_pkg::V_VERSION;
        end else if (hb_ext > i_segment_length || hb_ext < ihv_pkg::MIN_HDR
                     || i_packet_length == hb_ext) begin
            early_v = ihv_pkg::V_HDRLEN;
        end else if (tot_in <= hb_ext || tot_in > i_packet_length) begin
            early_v = ihv_pkg::V_TOTLEN;
        end else begin
            early_v = ihv_pkg::V_ACCEPT;
        end

        if (i_accept) begin
            if (i_first_word) begin
                n_header_words = i_header_word[27:24];
                n_word_index   = 4'd0;
                n_pkt          = i_packet_length;
                n_tot          = tot_in;
                n_flags        = {i_nic_sum_bad, i_nic_sum_good};
                n_sum          = ihv_pkg::fold_add(16'd0, i_header_word);
                o_rec.early    = 1'b1;
                o_rec.verdict  = early_v;
                o_rec.hbytes   = hb_in;
                if (early_v != ihv_pkg::V_ACCEPT) begin
                    n_mode     = MODE_SKIP;
                    o_rec_push = 1'b1;
                end else begin
                    n_mode     = MODE_BUSY;
                end
            end else if (r_mode == MODE_BUSY) begin
                n_word_index = idx_inc;
                n_sum        = ihv_pkg::fold_add(r_sum, i_header_word);
                case (idx_inc)
                    4'd1:    n_frag  = i_header_word[12:0];
                    4'd2:    n_proto = i_header_word[23:16];
                    4'd3:    n_src   = i_header_word;
                    default: n_src   = r_src;
                endcase
                if ({1'b0, idx_inc} + 5'd1 >= {1'b0, r_header_words}) begin
                    n_mode        = MODE_IDLE;
                    o_rec_push    = 1'b1;
                    o_rec.early   = 1'b0;
                    o_rec.verdict = ihv_pkg::V_ACCEPT;
                    o_rec.hbytes  = {r_header_words, 2'b00};
                    o_rec.pkt     = r_pkt;
                    o_rec.tot     = r_tot;
                    o_rec.proto   = n_proto;
                    o_rec.frag    = n_frag;
                    o_rec.src     = n_src;
                    o_rec.flags   = r_flags;
                    o_rec.sum     = n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_word_index   <= 4'd0;
            r_header_words <= 4'd0;
            r_sum          <= 16'd0;
            r_flags        <= 2'b00;
        end else begin
            r_mode         <= n_mode;
            r_word_index   <= n_word_index;
            r_header_words <= n_header_words;
            r_sum          <= n_sum;
            r_flags        <= n_flags;
        end
        r_pkt   <= n_pkt;
        r_tot   <= n_tot;
        r_proto <= n_proto;
        r_frag  <= n_frag;
        r_src   <= n_src;
    end

`ifndef SYNTHESIS
    a_busy_min_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_BUSY |-> r_header_words >= 4'd5)
        else $error("busy packet with short header length");
    a_busy_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_BUSY |-> ({1'b0, r_word_index} + 5'd1 < {1'b0, r_header_words}))
        else $error("busy packet past its last header word");
`endif

endmodule

`default_nettype wire

>>> rtl/ihv_fifo.sv
// Short register queue between the front end and the back end.
`default_nettype none

module ihv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WIDTH-1:0]  i_data,
    input  wire logic              i_pop,
    output logic [WIDTH-1:0]       o_data,
    output logic                   o_full,
    output logic                   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("transaction pushed into full queue");
`endif

endmodule

`default_nettype wire

>>> rtl/ihv_back.sv
// Back end: final protocol, source, fragment and checksum checks into the result register.
`default_nettype none

module ihv_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ihv_pkg::t_rec  i_rec,
    input  wire logic           i_rec_empty,
    output logic                o_rec_pop,
    input  wire logic           i_pop,
    output ihv_pkg::t_result    o_result,
    output logic                o_empty
);

    logic              r_valid, n_valid;
    ihv_pkg::t_result  r_result, n_result;
    ihv_pkg::t_result  res;
    logic [16:0]       frag_end;
    logic              src_bad;

    assign frag_end = {1'b0, i_rec.frag, 3'b000} + {1'b0, i_rec.tot};
    assign src_bad  = (i_rec.src == ihv_pkg::SRC_ZERO) || (i_rec.src == ihv_pkg::SRC_BCAST)
                      || ((i_rec.src & ihv_pkg::MCAST_MASK) == ihv_pkg::MCAST_PREFIX);

    always_comb begin
        res.header_bytes   = i_rec.hbytes;
        res.trim_bytes     = 16'd0;
        res.l4_class       = ihv_pkg::L4_NONE;
        res.source_address = 32'd0;
        res.verdict        = ihv_pkg::V_ACCEPT;
        if (i_rec.early) begin
            res.verdict = i_rec.verdict;
        end else begin
            res.source_address = i_rec.src;
            if (!(i_rec.proto inside {ihv_pkg::PROTO_HOPOPT, ihv_pkg::PROTO_ICMP,
                                      ihv_pkg::PROTO_TCP, ihv_pkg::PROTO_UDP})) begin
                res.verdict = ihv_pkg::V_PROTO;
            end else begin
                res.trim_bytes = i_rec.pkt - i_rec.tot;
                if (src_bad) begin
                    res.verdict = ihv_pkg::V_SOURCE;
                end else if (frag_end > ihv_pkg::MAX_LEN) begin
                    res.verdict = ihv_pkg::V_FRAGMENT;
                end else if (i_rec.flags[0]) begin
                    res.verdict = ihv_pkg::V_ACCEPT;
                end else if (i_rec.flags[1]) begin
                    res.verdict = ihv_pkg::V_CHECKSUM;
                end else if (i_rec.sum != ihv_pkg::SUM_GOOD) begin
                    res.verdict = ihv_pkg::V_CHECKSUM;
                end
                if (res.verdict == ihv_pkg::V_ACCEPT) begin
                    if (i_rec.proto == ihv_pkg::PROTO_TCP) begin
                        res.l4_class = ihv_pkg::L4_TCP;
                    end else if (i_rec.proto == ihv_pkg::PROTO_UDP) begin
                        res.l4_class = ihv_pkg::L4_UDP;
                    end
                end
            end
        end
    end

    assign o_rec_pop = !i_rec_empty && (!r_valid || i_pop);

    always_comb begin
        n_valid  = r_valid;
        n_result = r_result;
        if (o_rec_pop) begin
            n_valid  = 1'b1;
            n_result = res;
        end else if (i_pop) begin
            n_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_result <= n_result;
    end

    assign o_result = r_result;
    assign o_empty  = !r_valid;

`ifndef SYNTHESIS
    a_class_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.l4_class != ihv_pkg::L4_NONE
        |-> r_result.verdict == ihv_pkg::V_ACCEPT)
        else $error("layer-4 class on rejected packet");
    a_early_no_trim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_result.verdict == ihv_pkg::V_SHORT
                    || r_result.verdict == ihv_pkg::V_VERSION
                    || r_result.verdict == ihv_pkg::V_HDRLEN
                    || r_result.verdict == ihv_pkg::V_TOTLEN
                    || r_result.verdict == ihv_pkg::V_PROTO)
        |-> r_result.trim_bytes == 16'd0)
        else $error("trim length on early verdict");
`endif

endmodule

`default_nettype wire

>>> rtl/ipv4_rx_header_validator_core.sv
// Top level of the IPv4 receive header validator.
// Input queue side: drive i_push with one 32-bit header word and its side fields;
// the word is taken at a clock edge with i_push high and o_full low. i_first_word
// marks the first word of a packet; segment length, packet length and the NIC
// checksum flags count on that word only.
// Result queue side: while o_empty is low the oldest verdict is on the o_ ports and
// leaves at an edge with i_pop high. One result per packet: on the first word when
// it already fails, else on the last header word (IHL words in all).
// A result is queued, then registered at the output. One word per cycle is sustained
// while o_full is low. The front end folds the checksum with one add per word;
// the back end runs the final checks from a two-entry queue into an output register.
// When the receiver stalls, the queue fills and o_full rises after two more results.
// Reset (i_rst_n low, synchronous) empties both queues and drops any open packet.
`default_nettype none

module ipv4_rx_header_validator_core #(
    parameter int MID_DEPTH = ihv_pkg::MID_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic          i_first_word,
    input  wire logic [31:0]   i_header_word,
    input  wire logic [15:0]   i_segment_length,
    input  wire logic [15:0]   i_packet_length,
    input  wire logic          i_nic_sum_good,
    input  wire logic          i_nic_sum_bad,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [3:0]         o_verdict,
    output logic [15:0]        o_trim_bytes,
    output logic [1:0]         o_l4_class,
    output logic [5:0]         o_header_bytes,
    output logic [31:0]        o_source_address
);

    localparam int REC_W = $bits(ihv_pkg::t_rec);

    logic               accept;
    ihv_pkg::t_rec      front_rec;
    logic               front_push;
    logic [REC_W-1:0]   mid_data;
    ihv_pkg::t_rec      mid_rec;
    logic               mid_empty;
    logic               mid_pop;
    ihv_pkg::t_result   result;

    assign accept  = i_push && !o_full;
    assign mid_rec = ihv_pkg::t_rec'(mid_data);

    ihv_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_first_word     (i_first_word),
        .i_header_word    (i_header_word),
        .i_segment_length (i_segment_length),
        .i_packet_length  (i_packet_length),
        .i_nic_sum_good   (i_nic_sum_good),
        .i_nic_sum_bad    (i_nic_sum_bad),
        .o_rec            (front_rec),
        .o_rec_push       (front_push)
    );

    ihv_fifo #(
        .WIDTH (REC_W),
        .DEPTH (MID_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (REC_W'(front_rec)),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_full  (o_full),
        .o_empty (mid_empty)
    );

    ihv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (mid_rec),
        .i_rec_empty (mid_empty),
        .o_rec_pop   (mid_pop),
        .i_pop       (i_pop),
        .o_result    (result),
        .o_empty     (o_empty)
    );

    assign o_verdict        = result.verdict;
    assign o_trim_bytes     = result.trim_bytes;
    assign o_l4_class       = result.l4_class;
    assign o_header_bytes   = result.header_bytes;
    assign o_source_address = result.source_address;

endmodule

`default_nettype wire
